// File: rtl/eniq_pkg.sv
// Package for the encoder and button input qualifier.
// Holds the transaction types, register map, reset values and the half-step decoder table.
// No dependencies.
package eniq_pkg;

    // Register indices on the configuration port; the byte address is 4*index
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [2:0] REG_DEBOUNCE_TIME     = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS_TIME   = 3'd1;
    localparam logic [2:0] REG_BACK_LONG_TIME    = 3'd2;
    localparam logic [2:0] REG_REVERSE_DIRECTION = 3'd3;
    localparam logic [2:0] REG_BUTTON_ACTIVE_LOW = 3'd4;

    // Register reset values
    localparam logic [15:0] DEBOUNCE_TIME_RST   = 16'd20;
    localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd600;
    localparam logic [15:0] BACK_LONG_TIME_RST  = 16'd2000;
    localparam logic        REVERSE_DIR_RST     = 1'b0;
    localparam logic        ACTIVE_LOW_RST      = 1'b1;

    // Rotation codes
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;

    // One poll of the pins
    typedef struct packed {
        logic        pin_a;
        logic        pin_b;
        logic        button_level;
        logic        back_level;
        logic [31:0] now_ms;
    } in_item_t;

    // Events reported for one poll
    typedef struct packed {
        logic [1:0] rotation;
        logic       click;
        logic       long_press;
        logic       back_press;
        logic       back_long_press;
    } out_item_t;

    // Events from one debounced button
    typedef struct packed {
        logic long_hit;      // held past the long time
        logic press_edge;    // accepted press
        logic release_edge;  // accepted release with no long press before it
    } qual_evt_t;

    // Half-step decoder states
    typedef enum logic [2:0] {
        ST_START       = 3'd0,
        ST_CCW_BEGIN   = 3'd1,
        ST_CW_BEGIN    = 3'd2,
        ST_START_M     = 3'd3,
        ST_CW_BEGIN_M  = 3'd4,
        ST_CCW_BEGIN_M = 3'd5
    } dec_state_t;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_CW   = 2'd1,
        EMIT_CCW  = 2'd2
    } dec_emit_t;

    typedef struct packed {
        dec_state_t nxt;
        dec_emit_t  emit;
    } dec_step_t;

    // Transition table; code is {pin_a, pin_b}. Unused state codes act as start.
    function automatic dec_step_t dec_step(input dec_state_t st, input logic [1:0] code);
        dec_step_t r;
        r.emit = EMIT_NONE;
        r.nxt  = ST_START;
        unique case (st)
            ST_CCW_BEGIN:
            begin
                case (code)
                    2'd0:    begin r.nxt = ST_START_M; r.emit = EMIT_CCW; end
                    2'd2:    r.nxt = ST_CCW_BEGIN;
                    default: r.nxt = ST_START;
                endcase
            end
            ST_CW_BEGIN:
            begin
                case (code)
                    2'd0:    begin r.nxt = ST_START_M; r.emit = EMIT_CW; end
                    2'd1:    r.nxt = ST_CW_BEGIN;
                    default: r.nxt = ST_START;
                endcase
            end
            ST_START_M:
            begin
                case (code)
                    2'd0:    r.nxt = ST_START_M;
                    2'd1:    r.nxt = ST_CCW_BEGIN_M;
                    2'd2:    r.nxt = ST_CW_BEGIN_M;
                    default: r.nxt = ST_START;
                endcase
            end
            ST_CW_BEGIN_M:
            begin
                case (code)
                    2'd2:    r.nxt = ST_CW_BEGIN_M;
                    2'd3:    begin r.nxt = ST_START; r.emit = EMIT_CW; end
                    default: r.nxt = ST_START_M;
                endcase
            end
            ST_CCW_BEGIN_M:
            begin
                case (code)
                    2'd1:    r.nxt = ST_CCW_BEGIN_M;
                    2'd3:    begin r.nxt = ST_START; r.emit = EMIT_CCW; end
                    default: r.nxt = ST_START_M;
                endcase
            end
            default:
            begin
                case (code)
                    2'd0:    r.nxt = ST_START_M;
                    2'd1:    r.nxt = ST_CW_BEGIN;
                    2'd2:    r.nxt = ST_CCW_BEGIN;
                    default: r.nxt = ST_START;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// File: rtl/eniq_debounce.sv
// Debounce and long-press qualifier for one button.
// State advances once per poll when step_en is high. Depends on eniq_pkg.
module eniq_debounce
    import eniq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic        raw,           // pressed meaning, not the pin level
    input  logic [31:0] now_ms,
    input  logic [15:0] debounce_time,
    input  logic [15:0] hold_time,
    output qual_evt_t   evt
);

    logic        last_raw_reg, last_raw_next;
    logic [31:0] change_time_reg, change_time_next;
    logic        stable_reg, stable_next;
    logic [31:0] press_time_reg, press_time_next;
    logic        long_done_reg, long_done_next;

    logic [31:0] since_change;
    logic [31:0] since_press;

    assign since_change = now_ms - change_time_reg;
    assign since_press  = now_ms - press_time_reg;

    // Per-poll qualification
    always_comb
    begin
        last_raw_next    = last_raw_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        press_time_next  = press_time_reg;
        long_done_next   = long_done_reg;
        evt              = '0;
        if (raw != last_raw_reg)
        begin
            // raw level moved: restart the settle window
            last_raw_next    = raw;
            change_time_next = now_ms;
        end
        else if (since_change < {16'd0, debounce_time})
        begin
            // still settling
        end
        else if (raw == stable_reg)
        begin
            if (stable_reg && !long_done_reg && (since_press >= {16'd0, hold_time}))
            begin
                long_done_next = 1'b1;
                evt.long_hit   = 1'b1;
            end
        end
        else
        begin
            stable_next = raw;
            if (raw)
            begin
                press_time_next = now_ms;
                long_done_next  = 1'b0;
                evt.press_edge  = 1'b1;
            end
            else
            begin
                evt.release_edge = !long_done_reg;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg    <= 1'b0;
            change_time_reg <= '0;
            stable_reg      <= 1'b0;
            press_time_reg  <= '0;
            long_done_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            last_raw_reg    <= last_raw_next;
            change_time_reg <= change_time_next;
            stable_reg      <= stable_next;
            press_time_reg  <= press_time_next;
            long_done_reg   <= long_done_next;
        end
    end

endmodule

// File: rtl/encoder_and_button_input_qualifier.sv
// Encoder and button input qualifier, top level.
// Depends on eniq_pkg and eniq_debounce.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one poll of the
//   encoder pins, both button levels and a millisecond timestamp.
//   Output channel (out_valid / out_stall / out_data) returns exactly one
//   transaction per poll: rotation step and button events, zero when idle.
//   A poll is registered on acceptance, decoded from the input register and
//   its result lands in the output register. One poll per cycle is sustained
//   while the receiver does not stall; the limit is the single pass through
//   the decoder table and the two debounce compares.
//   If the receiver stalls, the output register holds; one more poll can
//   wait in the input register, after which in_stall goes high.
//   Configuration goes through the APB port (registers at 4*index). The user
//   must only write it with no poll in flight; the block does not enforce it.
//   Reset clears the decoder to its start state, both debouncers to
//   released, and restores the register defaults (20, 600, 2000, 0, 1).
module encoder_and_button_input_qualifier
    import eniq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // poll input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    // result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers
    logic [15:0] debounce_time_reg;
    logic [15:0] long_press_time_reg;
    logic [15:0] back_long_time_reg;
    logic        reverse_dir_reg;
    logic        active_low_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg   <= DEBOUNCE_TIME_RST;
            long_press_time_reg <= LONG_PRESS_TIME_RST;
            back_long_time_reg  <= BACK_LONG_TIME_RST;
            reverse_dir_reg     <= REVERSE_DIR_RST;
            active_low_reg      <= ACTIVE_LOW_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DEBOUNCE_TIME:     debounce_time_reg   <= pwdata[15:0];
                REG_LONG_PRESS_TIME:   long_press_time_reg <= pwdata[15:0];
                REG_BACK_LONG_TIME:    back_long_time_reg  <= pwdata[15:0];
                REG_REVERSE_DIRECTION: reverse_dir_reg     <= pwdata[0];
                REG_BUTTON_ACTIVE_LOW: active_low_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_DEBOUNCE_TIME:     prdata = {16'd0, debounce_time_reg};
            REG_LONG_PRESS_TIME:   prdata = {16'd0, long_press_time_reg};
            REG_BACK_LONG_TIME:    prdata = {16'd0, back_long_time_reg};
            REG_REVERSE_DIRECTION: prdata = {31'd0, reverse_dir_reg};
            REG_BUTTON_ACTIVE_LOW: prdata = {31'd0, active_low_reg};
            default:               prdata = '0;
        endcase
    end

    // Input register and pipeline handshake
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      advance;
    logic      in_acc;

    assign advance  = in_valid_reg && !(out_valid && out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_acc || (in_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_item_reg <= in_data;
        end
    end

    // Half-step quadrature decoder
    dec_state_t dec_state_reg;
    dec_step_t  dec_res;
    logic [1:0] rotation;
    logic       cw;

    assign dec_res = dec_step(dec_state_reg, {in_item_reg.pin_a, in_item_reg.pin_b});
    assign cw      = (dec_res.emit == EMIT_CW) ^ reverse_dir_reg;

    always_comb
    begin
        if (dec_res.emit == EMIT_NONE)
        begin
            rotation = ROT_NONE;
        end
        else
        begin
            rotation = cw ? ROT_CW : ROT_CCW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_state_reg <= ST_START;
        end
        else if (advance)
        begin
            dec_state_reg <= dec_res.nxt;
        end
    end

    // Button qualifiers
    qual_evt_t btn_evt;
    qual_evt_t back_evt;
    logic      btn_raw;

    assign btn_raw = active_low_reg ? !in_item_reg.button_level : in_item_reg.button_level;

    eniq_debounce u_btn (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .raw           (btn_raw),
        .now_ms        (in_item_reg.now_ms),
        .debounce_time (debounce_time_reg),
        .hold_time     (long_press_time_reg),
        .evt           (btn_evt)
    );

    eniq_debounce u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .raw           (!in_item_reg.back_level),
        .now_ms        (in_item_reg.now_ms),
        .debounce_time (debounce_time_reg),
        .hold_time     (back_long_time_reg),
        .evt           (back_evt)
    );

    // Result register
    out_item_t result;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    always_comb
    begin
        result.rotation        = rotation;
        result.click           = btn_evt.release_edge;
        result.long_press      = btn_evt.long_hit;
        result.back_press      = back_evt.press_edge;
        result.back_long_press = back_evt.long_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// File: rtl/eniq_checker.sv
// Port-level checks for the encoder and button input qualifier.
// Depends on eniq_pkg; bound to the top level at the end of this file.
module eniq_checker
    import eniq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result transaction changed");

    // Rotation only ever reports none, clockwise or counterclockwise
    a_rot_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.rotation == ROT_NONE) || (out_data.rotation == ROT_CW) ||
                      (out_data.rotation == ROT_CCW))
        else $error("invalid rotation code");

    // Click and long press come from different debounce branches
    a_btn_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.click && out_data.long_press))
        else $error("click and long press in one poll");

    // Back press edge and back long press cannot share a poll
    a_back_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.back_press && out_data.back_long_press))
        else $error("back press and back long press in one poll");

endmodule

bind encoder_and_button_input_qualifier eniq_checker u_eniq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: tb/sv/encoder_and_button_input_qualifier_tb.sv
// Testbench for the encoder and button input qualifier: directed polls, then random polls
// over several register settings and idle patterns, checked against a predictor of the block.
// Depends on eniq_pkg and the encoder_and_button_input_qualifier RTL.
`timescale 1ns / 100ps

module encoder_and_button_input_qualifier_tb;
    import eniq_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned ITEMS_PER_MODE = 90;
    localparam int unsigned LONG_HOLD      = 80;

    // Debounce tracking for one button; levels carry the pressed meaning
    typedef struct {
        bit        last_raw;
        bit [31:0] change_ms;
        bit        stable;
        bit [31:0] press_ms;
        bit        long_done;
    } debounce_state_t;

    // Predicts the event transaction of every accepted poll and checks the results
    class poll_event_tracker;
        bit [15:0]       debounce_ms;
        bit [15:0]       long_ms;
        bit [15:0]       back_long_ms;
        bit              reverse_dir;
        bit              active_low;
        dec_state_t      dec_state;
        debounce_state_t push;
        debounce_state_t back;
        out_item_t       pending_events[$];
        int              failures;

        function new();
            debounce_ms  = DEBOUNCE_TIME_RST;
            long_ms      = LONG_PRESS_TIME_RST;
            back_long_ms = BACK_LONG_TIME_RST;
            reverse_dir  = REVERSE_DIR_RST;
            active_low   = ACTIVE_LOW_RST;
            dec_state    = ST_START;
            push         = '{default: 0};
            back         = '{default: 0};
            failures     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_DEBOUNCE_TIME:     debounce_ms  = value[15:0];
                REG_LONG_PRESS_TIME:   long_ms      = value[15:0];
                REG_BACK_LONG_TIME:    back_long_ms = value[15:0];
                REG_REVERSE_DIRECTION: reverse_dir  = value[0];
                REG_BUTTON_ACTIVE_LOW: active_low   = value[0];
                default: ;
            endcase
        endfunction

        // Half-step table; code is {pin_a, pin_b}
        function logic [1:0] decode_step(logic [1:0] code);
            dec_state_t nxt;
            dec_emit_t  emit;
            bit         cw;
            emit = EMIT_NONE;
            case (dec_state)
                ST_CCW_BEGIN:
                begin
                    nxt = (code == 2'b10) ? ST_CCW_BEGIN : ST_START;
                    if (code == 2'b00)
                    begin
                        nxt  = ST_START_M;
                        emit = EMIT_CCW;
                    end
                end
                ST_CW_BEGIN:
                begin
                    nxt = (code == 2'b01) ? ST_CW_BEGIN : ST_START;
                    if (code == 2'b00)
                    begin
                        nxt  = ST_START_M;
                        emit = EMIT_CW;
                    end
                end
                ST_START_M:
                begin
                    case (code)
                        2'b00:   nxt = ST_START_M;
                        2'b01:   nxt = ST_CCW_BEGIN_M;
                        2'b10:   nxt = ST_CW_BEGIN_M;
                        default: nxt = ST_START;
                    endcase
                end
                ST_CW_BEGIN_M:
                begin
                    nxt = (code == 2'b10) ? ST_CW_BEGIN_M : ST_START_M;
                    if (code == 2'b11)
                    begin
                        nxt  = ST_START;
                        emit = EMIT_CW;
                    end
                end
                ST_CCW_BEGIN_M:
                begin
                    nxt = (code == 2'b01) ? ST_CCW_BEGIN_M : ST_START_M;
                    if (code == 2'b11)
                    begin
                        nxt  = ST_START;
                        emit = EMIT_CCW;
                    end
                end
                // start state, and the two unused codes behave like it
                default:
                begin
                    case (code)
                        2'b00:   nxt = ST_START_M;
                        2'b01:   nxt = ST_CW_BEGIN;
                        2'b10:   nxt = ST_CCW_BEGIN;
                        default: nxt = ST_START;
                    endcase
                end
            endcase
            dec_state = nxt;
            if (emit == EMIT_NONE)
                return ROT_NONE;
            cw = (emit == EMIT_CW) ^ reverse_dir;
            return cw ? ROT_CW : ROT_CCW;
        endfunction

        // One debounced button poll; time differences wrap at 32 bits
        function void qualify(inout debounce_state_t s, input bit raw, input bit [31:0] now,
                              input bit [31:0] hold, output bit held_long,
                              output bit pressed, output bit released);
            bit [31:0] since_change;
            bit [31:0] since_press;
            held_long    = 1'b0;
            pressed      = 1'b0;
            released     = 1'b0;
            since_change = now - s.change_ms;
            since_press  = now - s.press_ms;
            if (raw != s.last_raw)
            begin
                s.last_raw  = raw;
                s.change_ms = now;
                return;
            end
            if (since_change < {16'd0, debounce_ms})
                return;
            if (raw == s.stable)
            begin
                if (s.stable && !s.long_done && since_press >= hold)
                begin
                    s.long_done = 1'b1;
                    held_long   = 1'b1;
                end
                return;
            end
            s.stable = raw;
            if (raw)
            begin
                s.press_ms  = now;
                s.long_done = 1'b0;
                pressed     = 1'b1;
            end
            else
                released = 1'b1;
        endfunction

        function void note_poll(in_item_t p);
            out_item_t ev;
            bit        held_long;
            bit        pressed;
            bit        released;
            ev.rotation = decode_step({p.pin_a, p.pin_b});
            qualify(push, active_low ? !p.button_level : p.button_level, p.now_ms,
                    {16'd0, long_ms}, held_long, pressed, released);
            ev.long_press = held_long;
            ev.click      = released && !push.long_done;
            qualify(back, !p.back_level, p.now_ms, {16'd0, back_long_ms},
                    held_long, pressed, released);
            ev.back_long_press = held_long;
            ev.back_press      = pressed;
            pending_events.push_back(ev);
        endfunction

        function void field_check(string name, logic [1:0] want, logic [1:0] seen);
            if (seen !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
                failures++;
            end
        endfunction

        function void check_events(out_item_t got);
            out_item_t want;
            if (pending_events.size() == 0)
            begin
                $error("result transaction with no poll pending");
                failures++;
                return;
            end
            want = pending_events.pop_front();
            field_check("rotation", want.rotation, got.rotation);
            field_check("click", {1'b0, want.click}, {1'b0, got.click});
            field_check("long_press", {1'b0, want.long_press}, {1'b0, got.long_press});
            field_check("back_press", {1'b0, want.back_press}, {1'b0, got.back_press});
            field_check("back_long_press", {1'b0, want.back_long_press},
                        {1'b0, got.back_long_press});
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    poll_event_tracker tracker;
    int unsigned       cycle_count = 0;
    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    int unsigned       stall_left = 0;
    bit                long_hold_req;
    bit                long_hold_done = 1'b0;

    // random poll generator state
    bit [31:0]   cur_ms;
    bit [1:0]    enc_code;
    bit          enc_cw;
    bit          push_down;
    bit          back_down;
    int unsigned push_hold_left;
    int unsigned back_hold_left;

    encoder_and_button_input_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when asked for one
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            stall_left     = LONG_HOLD - 1;
            out_stall     <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_events(out_data);
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offer one poll and wait until the block takes it
    task automatic send_poll(input in_item_t p);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_poll(p);
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_events.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // APB write: setup, access, then back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] word;
        word = {16'($urandom_range(16'hFFFF, 0)), value};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic in_item_t mk_poll(bit a, bit b, bit btn, bit bk, bit [31:0] now);
        in_item_t p;
        p.pin_a        = a;
        p.pin_b        = b;
        p.button_level = btn;
        p.back_level   = bk;
        p.now_ms       = now;
        return p;
    endfunction

    // Gray-code step of the encoder in either direction
    function automatic bit [1:0] enc_next(bit [1:0] code, bit cw);
        case (code)
            2'b11:   return cw ? 2'b01 : 2'b10;
            2'b01:   return cw ? 2'b00 : 2'b11;
            2'b00:   return cw ? 2'b10 : 2'b01;
            default: return cw ? 2'b11 : 2'b00;
        endcase
    endfunction

    // Polls a button level stays put: bounces, ordinary presses, long holds
    function automatic int unsigned pick_hold();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25)
            return $urandom_range(2, 1);
        if (r < 75)
            return $urandom_range(20, 3);
        return $urandom_range(60, 20);
    endfunction

    function automatic in_item_t next_random_poll();
        int unsigned r;
        int unsigned unit;
        r    = $urandom_range(99);
        unit = (int'(tracker.long_ms) + int'(tracker.back_long_ms)) / 32 + 1;
        // time moves mostly forward in steps scaled to the hold times
        if (r < 30)
            cur_ms += $urandom_range(3, 0);
        else if (r < 70)
            cur_ms += $urandom_range(unit, 0);
        else if (r < 95)
            cur_ms += $urandom_range(4 * unit, unit);
        else
            cur_ms = $urandom;
        // encoder walk, with reversals, holds and illegal jumps
        r = $urandom_range(99);
        if (r < 60)
            enc_code = enc_next(enc_code, enc_cw);
        else if (r < 72)
            enc_code = enc_code;
        else if (r < 82)
            enc_code = enc_next(enc_code, !enc_cw);
        else if (r < 90)
            enc_cw = !enc_cw;
        else
            enc_code = 2'($urandom_range(3, 0));
        if (push_hold_left == 0)
        begin
            push_down      = !push_down;
            push_hold_left = pick_hold();
        end
        else
            push_hold_left--;
        if (back_hold_left == 0)
        begin
            back_down      = !back_down;
            back_hold_left = pick_hold();
        end
        else
            back_hold_left--;
        return mk_poll(enc_code[1], enc_code[0], push_down ^ tracker.active_low,
                       !back_down, cur_ms);
    endfunction

    initial
    begin
        tracker        = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        long_hold_req  = 1'b0;
        cur_ms         = 0;
        enc_code       = 2'b11;
        enc_cw         = 1'b1;
        push_down      = 1'b0;
        back_down      = 1'b0;
        push_hold_left = 5;
        back_hold_left = 8;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed polls under reset settings
        send_poll(mk_poll(1, 1, 1, 1, 0));
        // clockwise into both rest positions
        send_poll(mk_poll(0, 1, 1, 1, 5));
        send_poll(mk_poll(0, 0, 1, 1, 10));
        send_poll(mk_poll(1, 0, 1, 1, 15));
        send_poll(mk_poll(1, 1, 1, 1, 20));
        // counterclockwise into both rest positions
        send_poll(mk_poll(1, 0, 1, 1, 25));
        send_poll(mk_poll(0, 0, 1, 1, 30));
        send_poll(mk_poll(0, 1, 1, 1, 35));
        send_poll(mk_poll(1, 1, 1, 1, 40));
        // jumps across two pin changes give no step
        send_poll(mk_poll(0, 0, 1, 1, 45));
        send_poll(mk_poll(1, 1, 1, 1, 50));
        // push button: settle edge, long press, release with no click
        send_poll(mk_poll(1, 1, 0, 1, 100));
        send_poll(mk_poll(1, 1, 0, 1, 119));
        send_poll(mk_poll(1, 1, 0, 1, 120));
        send_poll(mk_poll(1, 1, 0, 1, 719));
        send_poll(mk_poll(1, 1, 0, 1, 720));
        send_poll(mk_poll(1, 1, 1, 1, 800));
        send_poll(mk_poll(1, 1, 1, 1, 820));
        // short press with click, back press and back long press
        send_poll(mk_poll(1, 1, 0, 0, 900));
        send_poll(mk_poll(1, 1, 0, 0, 920));
        send_poll(mk_poll(1, 1, 1, 0, 930));
        send_poll(mk_poll(1, 1, 1, 0, 950));
        send_poll(mk_poll(1, 1, 1, 0, 2920));
        // back release settling across the 32-bit time wrap
        send_poll(mk_poll(1, 1, 1, 1, 32'hFFFF_FFF8));
        send_poll(mk_poll(1, 1, 1, 1, 32'h0000_000C));
        cur_ms = 32'h0000_000C;

        // Random polls over register settings and idle patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    write_reg(REG_DEBOUNCE_TIME, DEBOUNCE_TIME_RST);
                    write_reg(REG_LONG_PRESS_TIME, LONG_PRESS_TIME_RST);
                    write_reg(REG_BACK_LONG_TIME, BACK_LONG_TIME_RST);
                    write_reg(REG_REVERSE_DIRECTION, {15'd0, REVERSE_DIR_RST});
                    write_reg(REG_BUTTON_ACTIVE_LOW, {15'd0, ACTIVE_LOW_RST});
                end
                1:
                begin
                    write_reg(REG_DEBOUNCE_TIME, 16'd0);
                    write_reg(REG_LONG_PRESS_TIME, 16'd0);
                    write_reg(REG_BACK_LONG_TIME, 16'd0);
                    write_reg(REG_REVERSE_DIRECTION, 16'd1);
                    write_reg(REG_BUTTON_ACTIVE_LOW, 16'd0);
                end
                2:
                begin
                    write_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
                    write_reg(REG_LONG_PRESS_TIME, 16'hFFFF);
                    write_reg(REG_BACK_LONG_TIME, 16'hFFFF);
                    write_reg(REG_REVERSE_DIRECTION, 16'd1);
                    write_reg(REG_BUTTON_ACTIVE_LOW, 16'd1);
                    cur_ms = 32'hFFF0_0000;
                end
                default:
                begin
                    write_reg(REG_DEBOUNCE_TIME, 16'($urandom_range(64, 0)));
                    write_reg(REG_LONG_PRESS_TIME, 16'($urandom_range(1500, 0)));
                    write_reg(REG_BACK_LONG_TIME, 16'($urandom_range(3000, 0)));
                    write_reg(REG_REVERSE_DIRECTION, 16'($urandom_range(1, 0)));
                    write_reg(REG_BUTTON_ACTIVE_LOW, 16'($urandom_range(1, 0)));
                    cur_ms = $urandom;
                end
            endcase
            for (int mode = 0; mode < 4; mode++)
            begin
                case (mode)
                    0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                    1:       begin send_idle_pct = 74; stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  stall_pct = 74; end
                    default: begin send_idle_pct = 31; stall_pct = 31; end
                endcase
                for (int n = 0; n < ITEMS_PER_MODE; n++)
                begin
                    // long receiver hold-off while polls keep coming
                    if (phase == 0 && mode == 0 && n == 30)
                        long_hold_req = 1'b1;
                    // sender waits for every result mid-stream
                    if (mode == 3 && n == 45)
                        wait_drained();
                    send_poll(next_random_poll());
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending_events.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
